### hdl/tts_pkg.sv
// Shared constants, codes, types and helpers for the tick task scheduler table.
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int RESULT_CAP = 8;
   localparam int COUNT_W    = $clog2(RESULT_CAP + 1);
   localparam int CD_W       = 17;
   localparam int TIME_W     = 16;
   localparam int HANDLE_W   = 8;
   localparam int PEND_W     = 8;
   localparam int FIELD_SLOT_W = 3;
   localparam int PAD_W      = 6;

   localparam logic [PEND_W-1:0] PENDING_MAX = 8'hFF;

   localparam logic [1:0] CMD_ADD      = 2'd0;
   localparam logic [1:0] CMD_TICK     = 2'd1;
   localparam logic [1:0] CMD_DISPATCH = 2'd2;
   localparam logic [1:0] CMD_DELETE   = 2'd3;

   localparam logic [1:0] KIND_ADD      = 2'd0;
   localparam logic [1:0] KIND_DISPATCH = 2'd1;
   localparam logic [1:0] KIND_DELETE   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [1:0] STATUS_NOTHING = 2'd3;

   // Commands from the controller to the slot table.
   typedef struct packed {
      logic              load;
      logic              add;
      logic              tick;
      logic              disp;
      logic              del;
      logic              empty;
      logic              last;
      logic [SLOT_W-1:0] index;
   } tts_cmd_type;

   // Status from the slot table back to the controller.
   typedef struct packed {
      logic slot_ready;
      logic more_after;
   } tts_stat_type;

   // Reports a slot number on the three-bit result field (low bits).
   function automatic logic [FIELD_SLOT_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
      logic [PAD_W-1:0] wide;
      wide = PAD_W'(idx);
      return wide[FIELD_SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

### hdl/tts_ctrl.sv
// Controller state machine that sequences commands over the slot table.
`timescale 1ns / 1ps
`default_nettype none
module tts_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            req_command,
   input  wire tts_pkg::tts_stat_type stat,
   output tts_pkg::tts_cmd_type       cmd,
   output logic                       busy
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   localparam logic [tts_pkg::SLOT_W-1:0] LAST_IDX =
      tts_pkg::SLOT_W'(tts_pkg::NUM_SLOTS - 1);
   localparam logic [tts_pkg::COUNT_W-1:0] CAP_LAST =
      tts_pkg::COUNT_W'(tts_pkg::RESULT_CAP - 1);

   logic [1:0]                   state_ff, state_in;
   logic [1:0]                   op_ff, op_in;
   logic [tts_pkg::SLOT_W-1:0]   idx_ff, idx_in;
   logic [tts_pkg::COUNT_W-1:0]  n_ff, n_in;
   logic                         last_entry;

   assign busy = (state_ff != ST_IDLE);
   assign last_entry = (n_ff == CAP_LAST) || !stat.more_after;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      cmd      = '0;
      cmd.index = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_command;
               idx_in   = '0;
               n_in     = '0;
               if (req_command == tts_pkg::CMD_TICK ||
                   req_command == tts_pkg::CMD_DISPATCH) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            cmd.add  = (op_ff == tts_pkg::CMD_ADD);
            cmd.del  = (op_ff == tts_pkg::CMD_DELETE);
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (op_ff == tts_pkg::CMD_TICK) begin
               cmd.tick = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (stat.slot_ready) begin
               cmd.disp = 1'b1;
               cmd.last = last_entry;
               n_in     = n_ff + 1'b1;
               if (last_entry) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (idx_ff == LAST_IDX) begin
               // No slot was pending anywhere in the table.
               cmd.empty = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= tts_pkg::CMD_ADD;
         idx_ff   <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
         n_ff     <= n_in;
      end
   end

endmodule
`default_nettype wire

### hdl/tts_datapath.sv
// Slot table storage, per-slot update logic and the registered result port.
`timescale 1ns / 1ps
`default_nettype none
module tts_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tts_pkg::tts_cmd_type           cmd,
   input  wire logic [tts_pkg::HANDLE_W-1:0]   req_task_handle,
   input  wire logic [tts_pkg::TIME_W-1:0]     req_start_delay,
   input  wire logic [tts_pkg::TIME_W-1:0]     req_period,
   input  wire logic [2:0]                     req_slot,
   output tts_pkg::tts_stat_type               stat,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_kind,
   output logic [2:0]                          rsp_slot_index,
   output logic [tts_pkg::HANDLE_W-1:0]        rsp_run_handle,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last
);

   localparam int N = tts_pkg::NUM_SLOTS;

   logic                          used_ff    [N];
   logic [tts_pkg::CD_W-1:0]      cd_ff      [N];
   logic [tts_pkg::TIME_W-1:0]    period_ff  [N];
   logic [tts_pkg::PEND_W-1:0]    pend_ff    [N];
   logic [tts_pkg::HANDLE_W-1:0]  handle_ff  [N];

   logic [tts_pkg::HANDLE_W-1:0]  rq_handle_ff;
   logic [tts_pkg::TIME_W-1:0]    rq_delay_ff;
   logic [tts_pkg::TIME_W-1:0]    rq_period_ff;
   logic [2:0]                    rq_slot_ff;

   logic                          valid_ff;
   logic [1:0]                    kind_ff;
   logic [2:0]                    slot_ff;
   logic [tts_pkg::HANDLE_W-1:0]  run_ff;
   logic [1:0]                    status_ff;
   logic                          last_ff;

   logic [N-1:0]                  ready;
   logic                          free_found;
   logic [tts_pkg::SLOT_W-1:0]    free_idx;
   logic                          del_in_range;
   logic [tts_pkg::SLOT_W-1:0]    del_idx;
   logic [tts_pkg::CD_W-1:0]      cd_dec;

   assign del_in_range = (32'(rq_slot_ff) < N);
   assign del_idx      = tts_pkg::SLOT_W'(rq_slot_ff);
   assign cd_dec       = cd_ff[cmd.index] - 1'b1;

   always_comb begin
      stat.more_after = 1'b0;
      free_found      = 1'b0;
      free_idx        = '0;
      for (int i = 0; i < N; i++) begin
         ready[i] = used_ff[i] && (pend_ff[i] != '0);
         if (ready[i] && (tts_pkg::SLOT_W'(i) > cmd.index)) begin
            stat.more_after = 1'b1;
         end
      end
      for (int i = N - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = tts_pkg::SLOT_W'(i);
         end
      end
      stat.slot_ready = ready[cmd.index];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rq_handle_ff <= req_task_handle;
         rq_delay_ff  <= req_start_delay;
         rq_period_ff <= req_period;
         rq_slot_ff   <= req_slot;
      end
      if (cmd.add && free_found) begin
         handle_ff[free_idx] <= rq_handle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            used_ff[i]   <= 1'b0;
            cd_ff[i]     <= '0;
            period_ff[i] <= '0;
            pend_ff[i]   <= '0;
         end
      end else if (cmd.add) begin
         if (free_found) begin
            used_ff[free_idx]   <= 1'b1;
            cd_ff[free_idx]     <= tts_pkg::CD_W'(rq_delay_ff) + 1'b1;
            period_ff[free_idx] <= rq_period_ff;
            pend_ff[free_idx]   <= '0;
         end
      end else if (cmd.tick) begin
         if (used_ff[cmd.index] && cd_ff[cmd.index] != '0) begin
            if (cd_dec == '0) begin
               if (pend_ff[cmd.index] != tts_pkg::PENDING_MAX) begin
                  pend_ff[cmd.index] <= pend_ff[cmd.index] + 1'b1;
               end
               cd_ff[cmd.index] <= tts_pkg::CD_W'(period_ff[cmd.index]);
            end else begin
               cd_ff[cmd.index] <= cd_dec;
            end
         end
      end else if (cmd.disp) begin
         if (period_ff[cmd.index] == '0) begin
            used_ff[cmd.index] <= 1'b0;
            cd_ff[cmd.index]   <= '0;
            pend_ff[cmd.index] <= '0;
         end else begin
            pend_ff[cmd.index] <= pend_ff[cmd.index] - 1'b1;
         end
      end else if (cmd.del && del_in_range) begin
         used_ff[del_idx]   <= 1'b0;
         cd_ff[del_idx]     <= '0;
         period_ff[del_idx] <= '0;
         pend_ff[del_idx]   <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.add || cmd.disp || cmd.del || cmd.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         kind_ff   <= tts_pkg::KIND_ADD;
         slot_ff   <= free_found ? tts_pkg::slot_field(free_idx) : 3'd0;
         run_ff    <= '0;
         status_ff <= free_found ? tts_pkg::STATUS_OK : tts_pkg::STATUS_FULL;
         last_ff   <= 1'b1;
      end else if (cmd.disp) begin
         kind_ff   <= tts_pkg::KIND_DISPATCH;
         slot_ff   <= tts_pkg::slot_field(cmd.index);
         run_ff    <= handle_ff[cmd.index];
         status_ff <= tts_pkg::STATUS_OK;
         last_ff   <= cmd.last;
      end else if (cmd.empty) begin
         kind_ff   <= tts_pkg::KIND_DISPATCH;
         slot_ff   <= 3'd0;
         run_ff    <= '0;
         status_ff <= tts_pkg::STATUS_NOTHING;
         last_ff   <= 1'b1;
      end else begin
         kind_ff   <= tts_pkg::KIND_DELETE;
         slot_ff   <= rq_slot_ff;
         run_ff    <= '0;
         status_ff <= (del_in_range && used_ff[del_idx]) ?
                      tts_pkg::STATUS_OK : tts_pkg::STATUS_EMPTY;
         last_ff   <= 1'b1;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_run_handle = run_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

endmodule
`default_nettype wire

### hdl/tick_task_scheduler_table_top.sv
// Top level of the tick task scheduler table: controller plus slot table datapath.
// Add and delete run in the cycle after the request is taken; the reply comes in the cycle after.
// Tick walks all NUM_SLOTS slots, one per cycle; dispatch stops at the last pending slot or
// after RESULT_CAP entries, each entry registered in the cycle after its slot is visited. A
// request is taken in the first cycle busy is low. Results cannot be stalled. Synchronous reset
// empties the table by clearing use flags, countdowns, periods and pending counts, not handles.
`timescale 1ns / 1ps
`default_nettype none
module tick_task_scheduler_table_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_command,
   input  wire logic [tts_pkg::HANDLE_W-1:0]  req_task_handle,
   input  wire logic [tts_pkg::TIME_W-1:0]    req_start_delay,
   input  wire logic [tts_pkg::TIME_W-1:0]    req_period,
   input  wire logic [2:0]                    req_slot,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_kind,
   output logic [2:0]                         rsp_slot_index,
   output logic [tts_pkg::HANDLE_W-1:0]       rsp_run_handle,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last
);

   // The controller owns the sequencing: it latches the command of each request,
   // steps the slot index during tick and dispatch, and decides which entry is last.
   tts_pkg::tts_cmd_type  cmd;
   tts_pkg::tts_stat_type stat;

   tts_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   // The datapath holds every slot and registers each result for exactly one cycle.
   tts_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_task_handle (req_task_handle),
      .req_start_delay (req_start_delay),
      .req_period      (req_period),
      .req_slot        (req_slot),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_run_handle  (rsp_run_handle),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire
